// ===== rtl/rlhc_pkg.sv =====
// shared types, constants and control codes of the ring lookup hop counter
`default_nettype none

package rlhc_pkg;

  // ring geometry
  localparam int MAX_RING = 1024;
  localparam int ADDR_W   = $clog2(MAX_RING);
  localparam int SIZE_W   = ADDR_W + 1;
  localparam int ENTRY_W  = ADDR_W + 1;
  localparam logic [SIZE_W-1:0] RING_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] RING_RESET = SIZE_W'(MAX_RING);

  // hop counter
  localparam int HOP_W = 5;
  localparam logic [HOP_W-1:0] HOP_LIMIT = HOP_W'(31);

  // commands
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_JOIN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // configuration register indexes
  localparam int PADDR_W = 3;
  localparam logic REG_RING_SIZE = 1'b0;

  // microcode step counter
  localparam int PC_W = 5;

  // datapath operations
  localparam int OP_W = 4;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_NONE        = 4'd0;
  localparam op_t OP_CLEAR       = 4'd1;
  localparam op_t OP_ACCEPT      = 4'd2;
  localparam op_t OP_QINIT       = 4'd3;
  localparam op_t OP_IV_INIT     = 4'd4;
  localparam op_t OP_HALVE       = 4'd5;
  localparam op_t OP_SUCC_RD_P   = 4'd6;
  localparam op_t OP_HOP         = 4'd7;
  localparam op_t OP_EMIT        = 4'd8;
  localparam op_t OP_SUCC_RD_KEY = 4'd9;
  localparam op_t OP_OWN_WR      = 4'd10;
  localparam op_t OP_JINIT       = 4'd11;
  localparam op_t OP_SUCC_RD_R   = 4'd12;
  localparam op_t OP_JSTEP       = 4'd13;

  // jump conditions
  localparam int COND_W = 4;
  typedef logic [COND_W-1:0] cond_t;
  localparam cond_t C_NEVER     = 4'd0;
  localparam cond_t C_ALWAYS    = 4'd1;
  localparam cond_t C_R_NOT_MAX = 4'd2;
  localparam cond_t C_NO_ITEM   = 4'd3;
  localparam cond_t C_IS_JOIN   = 4'd4;
  localparam cond_t C_IS_STORE  = 4'd5;
  localparam cond_t C_NOT_QUERY = 4'd6;
  localparam cond_t C_QBAD      = 4'd7;
  localparam cond_t C_QSTOP     = 4'd8;
  localparam cond_t C_IV_OVER   = 4'd9;
  localparam cond_t C_NOT_KNOWN = 4'd10;
  localparam cond_t C_OUT_BUSY  = 4'd11;
  localparam cond_t C_KEY_BAD   = 4'd12;
  localparam cond_t C_NODE_BAD  = 4'd13;
  localparam cond_t C_CNT_DONE  = 4'd14;
  localparam cond_t C_SELF      = 4'd15;

  // one control word of the microprogram
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // datapath flags tested by the sequencer
  typedef struct packed {
    logic r_not_max;
    logic no_item;
    logic is_join;
    logic is_store;
    logic not_query;
    logic qbad;
    logic qstop;
    logic iv_over;
    logic not_known;
    logic out_busy;
    logic key_bad;
    logic node_bad;
    logic cnt_done;
    logic self_link;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/rlhc_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module rlhc_seq (
  input  logic               clk,
  input  logic               rst,
  input  rlhc_pkg::status_t  status,
  output rlhc_pkg::ctrl_t    ctrl
);

  // program step addresses
  localparam logic [rlhc_pkg::PC_W-1:0] S_CLEAR   = 5'd0;
  localparam logic [rlhc_pkg::PC_W-1:0] S_IDLE    = 5'd1;
  localparam logic [rlhc_pkg::PC_W-1:0] S_DISP_J  = 5'd2;
  localparam logic [rlhc_pkg::PC_W-1:0] S_DISP_S  = 5'd3;
  localparam logic [rlhc_pkg::PC_W-1:0] S_DISP_Q  = 5'd4;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_INIT  = 5'd5;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_LOOP  = 5'd6;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_IV    = 5'd7;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_HALVE = 5'd8;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_READ  = 5'd9;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_CHECK = 5'd10;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_HOP   = 5'd11;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_EMIT  = 5'd12;
  localparam logic [rlhc_pkg::PC_W-1:0] S_Q_BACK  = 5'd13;
  localparam logic [rlhc_pkg::PC_W-1:0] S_S_READ  = 5'd14;
  localparam logic [rlhc_pkg::PC_W-1:0] S_S_WRITE = 5'd15;
  localparam logic [rlhc_pkg::PC_W-1:0] S_J_INIT  = 5'd16;
  localparam logic [rlhc_pkg::PC_W-1:0] S_J_LOOP  = 5'd17;
  localparam logic [rlhc_pkg::PC_W-1:0] S_J_CHECK = 5'd18;
  localparam logic [rlhc_pkg::PC_W-1:0] S_J_WRITE = 5'd19;

  logic [rlhc_pkg::PC_W-1:0] pc;
  logic [rlhc_pkg::PC_W-1:0] pc_next;
  logic                      take;

  function automatic rlhc_pkg::ctrl_t mk(input rlhc_pkg::op_t op,
                                         input rlhc_pkg::cond_t cond,
                                         input logic [rlhc_pkg::PC_W-1:0] target);
    rlhc_pkg::ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control rom
  function automatic rlhc_pkg::ctrl_t rom(input logic [rlhc_pkg::PC_W-1:0] a);
    rlhc_pkg::ctrl_t w;
    case (a)
      // clearing pass over both tables
      S_CLEAR:   w = mk(rlhc_pkg::OP_CLEAR, rlhc_pkg::C_R_NOT_MAX, S_CLEAR);
      // wait for a transaction and dispatch on the command
      S_IDLE:    w = mk(rlhc_pkg::OP_ACCEPT, rlhc_pkg::C_NO_ITEM, S_IDLE);
      S_DISP_J:  w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_IS_JOIN, S_J_INIT);
      S_DISP_S:  w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_IS_STORE, S_S_READ);
      S_DISP_Q:  w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_NOT_QUERY, S_IDLE);
      // query routing
      S_Q_INIT:  w = mk(rlhc_pkg::OP_QINIT, rlhc_pkg::C_QBAD, S_Q_EMIT);
      S_Q_LOOP:  w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_QSTOP, S_Q_EMIT);
      S_Q_IV:    w = mk(rlhc_pkg::OP_IV_INIT, rlhc_pkg::C_NEVER, S_IDLE);
      S_Q_HALVE: w = mk(rlhc_pkg::OP_HALVE, rlhc_pkg::C_IV_OVER, S_Q_HALVE);
      S_Q_READ:  w = mk(rlhc_pkg::OP_SUCC_RD_P, rlhc_pkg::C_NEVER, S_IDLE);
      S_Q_CHECK: w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_NOT_KNOWN, S_Q_EMIT);
      S_Q_HOP:   w = mk(rlhc_pkg::OP_HOP, rlhc_pkg::C_ALWAYS, S_Q_LOOP);
      S_Q_EMIT:  w = mk(rlhc_pkg::OP_EMIT, rlhc_pkg::C_OUT_BUSY, S_Q_EMIT);
      S_Q_BACK:  w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_ALWAYS, S_IDLE);
      // key store
      S_S_READ:  w = mk(rlhc_pkg::OP_SUCC_RD_KEY, rlhc_pkg::C_KEY_BAD, S_IDLE);
      S_S_WRITE: w = mk(rlhc_pkg::OP_OWN_WR, rlhc_pkg::C_ALWAYS, S_IDLE);
      // node join, walking backward
      S_J_INIT:  w = mk(rlhc_pkg::OP_JINIT, rlhc_pkg::C_NODE_BAD, S_IDLE);
      S_J_LOOP:  w = mk(rlhc_pkg::OP_SUCC_RD_R, rlhc_pkg::C_CNT_DONE, S_IDLE);
      S_J_CHECK: w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_SELF, S_IDLE);
      S_J_WRITE: w = mk(rlhc_pkg::OP_JSTEP, rlhc_pkg::C_ALWAYS, S_J_LOOP);
      default:   w = mk(rlhc_pkg::OP_NONE, rlhc_pkg::C_ALWAYS, S_IDLE);
    endcase
    return w;
  endfunction

  assign ctrl = rom(pc);

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      rlhc_pkg::C_NEVER:     take = 1'b0;
      rlhc_pkg::C_ALWAYS:    take = 1'b1;
      rlhc_pkg::C_R_NOT_MAX: take = status.r_not_max;
      rlhc_pkg::C_NO_ITEM:   take = status.no_item;
      rlhc_pkg::C_IS_JOIN:   take = status.is_join;
      rlhc_pkg::C_IS_STORE:  take = status.is_store;
      rlhc_pkg::C_NOT_QUERY: take = status.not_query;
      rlhc_pkg::C_QBAD:      take = status.qbad;
      rlhc_pkg::C_QSTOP:     take = status.qstop;
      rlhc_pkg::C_IV_OVER:   take = status.iv_over;
      rlhc_pkg::C_NOT_KNOWN: take = status.not_known;
      rlhc_pkg::C_OUT_BUSY:  take = status.out_busy;
      rlhc_pkg::C_KEY_BAD:   take = status.key_bad;
      rlhc_pkg::C_NODE_BAD:  take = status.node_bad;
      rlhc_pkg::C_CNT_DONE:  take = status.cnt_done;
      rlhc_pkg::C_SELF:      take = status.self_link;
      default:               take = 1'b0;
    endcase
  end

  assign pc_next = take ? ctrl.target : pc + 5'd1;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rlhc_dp.sv =====
// datapath: successor and owner tables, routing registers, result register
`default_nettype none

module rlhc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rlhc_pkg::ctrl_t               ctrl,
  input  logic [rlhc_pkg::SIZE_W-1:0]   ring_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rlhc_pkg::CMD_W-1:0]    cmd,
  input  logic [rlhc_pkg::ADDR_W-1:0]   node_id,
  input  logic [rlhc_pkg::ADDR_W-1:0]   key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rlhc_pkg::HOP_W-1:0]    hops,
  output rlhc_pkg::status_t             status
);

  // tables: {valid, position}
  logic [rlhc_pkg::ENTRY_W-1:0] succ_mem  [rlhc_pkg::MAX_RING];
  logic [rlhc_pkg::ENTRY_W-1:0] owner_mem [rlhc_pkg::MAX_RING];
  logic [rlhc_pkg::ENTRY_W-1:0] succ_rd;
  logic [rlhc_pkg::ENTRY_W-1:0] owner_rd;

  // transaction and routing registers
  logic [rlhc_pkg::CMD_W-1:0]  cmd_q;
  logic [rlhc_pkg::ADDR_W-1:0] node_q;
  logic [rlhc_pkg::ADDR_W-1:0] key_q;
  logic [rlhc_pkg::ADDR_W-1:0] cur;
  logic [rlhc_pkg::HOP_W-1:0]  hop_cnt;
  logic [rlhc_pkg::SIZE_W-1:0] rk;
  logic [rlhc_pkg::ADDR_W-1:0] iv;
  logic [rlhc_pkg::SIZE_W-1:0] cnt;
  logic [rlhc_pkg::ADDR_W-1:0] r;

  logic [rlhc_pkg::SIZE_W-1:0] node_w;
  logic [rlhc_pkg::SIZE_W-1:0] key_w;
  logic [rlhc_pkg::SIZE_W-1:0] cur_w;
  logic [rlhc_pkg::SIZE_W-1:0] rel_cur;
  logic [rlhc_pkg::SIZE_W-1:0] rk_init;
  logic [rlhc_pkg::SIZE_W-1:0] jump_sum;
  logic [rlhc_pkg::SIZE_W:0]   rel_jump;
  logic [rlhc_pkg::SIZE_W-1:0] p_wide;
  logic [rlhc_pkg::ADDR_W-1:0] p;
  logic [rlhc_pkg::SIZE_W-1:0] rs_m1;
  logic [rlhc_pkg::ADDR_W-1:0] r_dec;
  logic                        succ_known;
  logic                        owner_hit;
  logic                        out_busy;
  logic                        accept;

  logic                        succ_re;
  logic [rlhc_pkg::ADDR_W-1:0] succ_raddr;
  logic                        succ_we;
  logic [rlhc_pkg::ENTRY_W-1:0] succ_wdata;
  logic                        owner_we;
  logic [rlhc_pkg::ADDR_W-1:0] owner_waddr;
  logic [rlhc_pkg::ENTRY_W-1:0] owner_wdata;

  assign in_ready = (ctrl.op == rlhc_pkg::OP_ACCEPT);
  assign accept   = in_ready && in_valid;
  assign out_busy = out_valid && !out_ready;

  // ring-relative positions, measured from the start node
  assign node_w   = {1'b0, node_q};
  assign key_w    = {1'b0, key_q};
  assign cur_w    = {1'b0, cur};
  assign rel_cur  = (cur_w < node_w) ? cur_w + ring_size : cur_w;
  assign rk_init  = (key_w < node_w) ? key_w + ring_size : key_w;
  assign jump_sum = cur_w + {1'b0, iv};
  assign rel_jump = (jump_sum < node_w) ? {1'b0, jump_sum} + {1'b0, ring_size}
                                        : {1'b0, jump_sum};
  assign p_wide   = (jump_sum >= ring_size) ? jump_sum - ring_size : jump_sum;
  assign p        = p_wide[rlhc_pkg::ADDR_W-1:0];

  // backward step with wrap
  assign rs_m1 = ring_size - rlhc_pkg::SIZE_W'(1);
  assign r_dec = (r == '0) ? rs_m1[rlhc_pkg::ADDR_W-1:0] : r - rlhc_pkg::ADDR_W'(1);

  // a successor entry counts only if valid and inside the current ring
  assign succ_known = succ_rd[rlhc_pkg::ADDR_W] &&
                      ({1'b0, succ_rd[rlhc_pkg::ADDR_W-1:0]} < ring_size);
  assign owner_hit  = owner_rd[rlhc_pkg::ADDR_W] &&
                      (owner_rd[rlhc_pkg::ADDR_W-1:0] == cur);

  // flags for the sequencer
  always_comb begin
    status.r_not_max = (r != '1);
    status.no_item   = !in_valid;
    status.is_join   = (cmd_q == rlhc_pkg::CMD_JOIN);
    status.is_store  = (cmd_q == rlhc_pkg::CMD_STORE);
    status.not_query = (cmd_q != rlhc_pkg::CMD_QUERY);
    status.qbad      = (node_w >= ring_size) || (key_w >= ring_size);
    status.qstop     = (hop_cnt == rlhc_pkg::HOP_LIMIT) || owner_hit || (rel_cur >= rk);
    status.iv_over   = (iv != '0) && (rel_jump > {1'b0, rk});
    status.not_known = !succ_known;
    status.out_busy  = out_busy;
    status.key_bad   = (key_w >= ring_size);
    status.node_bad  = (node_w >= ring_size);
    status.cnt_done  = (cnt >= ring_size);
    status.self_link = succ_rd[rlhc_pkg::ADDR_W] && (succ_rd[rlhc_pkg::ADDR_W-1:0] == r);
  end

  // table port control
  always_comb begin
    succ_re     = 1'b0;
    succ_raddr  = r;
    succ_we     = 1'b0;
    succ_wdata  = '0;
    owner_we    = 1'b0;
    owner_waddr = r;
    owner_wdata = '0;
    case (ctrl.op)
      rlhc_pkg::OP_CLEAR: begin
        succ_we  = 1'b1;
        owner_we = 1'b1;
      end
      rlhc_pkg::OP_SUCC_RD_P: begin
        succ_re    = 1'b1;
        succ_raddr = p;
      end
      rlhc_pkg::OP_SUCC_RD_KEY: begin
        succ_re    = 1'b1;
        succ_raddr = key_q;
      end
      rlhc_pkg::OP_SUCC_RD_R: begin
        succ_re = 1'b1;
      end
      rlhc_pkg::OP_JSTEP: begin
        succ_we    = 1'b1;
        succ_wdata = {1'b1, node_q};
      end
      rlhc_pkg::OP_OWN_WR: begin
        owner_we    = 1'b1;
        owner_waddr = key_q;
        owner_wdata = succ_known ? succ_rd : '0;
      end
      default: begin
      end
    endcase
  end

  // successor table
  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[r] <= succ_wdata;
    end
    if (succ_re) begin
      succ_rd <= succ_mem[succ_raddr];
    end
  end

  // owner table, read once at the start of a query
  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[owner_waddr] <= owner_wdata;
    end
    if (ctrl.op == rlhc_pkg::OP_QINIT) begin
      owner_rd <= owner_mem[key_q];
    end
  end

  // walk pointer, also the clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
    end else begin
      case (ctrl.op)
        rlhc_pkg::OP_CLEAR: r <= r + rlhc_pkg::ADDR_W'(1);
        rlhc_pkg::OP_JINIT: r <= node_q;
        rlhc_pkg::OP_JSTEP: r <= r_dec;
        default:            r <= r;
      endcase
    end
  end

  // transaction capture and routing registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      node_q <= node_id;
      key_q  <= key;
    end
    case (ctrl.op)
      rlhc_pkg::OP_QINIT: begin
        hop_cnt <= '0;
        cur     <= node_q;
        rk      <= rk_init;
      end
      rlhc_pkg::OP_IV_INIT: begin
        iv <= ring_size[rlhc_pkg::SIZE_W-1:1];
      end
      rlhc_pkg::OP_HALVE: begin
        if (status.iv_over) begin
          iv <= iv >> 1;
        end
      end
      rlhc_pkg::OP_HOP: begin
        hop_cnt <= hop_cnt + rlhc_pkg::HOP_W'(1);
        cur     <= succ_rd[rlhc_pkg::ADDR_W-1:0];
      end
      rlhc_pkg::OP_JINIT: begin
        cnt <= '0;
      end
      rlhc_pkg::OP_JSTEP: begin
        cnt <= cnt + rlhc_pkg::SIZE_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == rlhc_pkg::OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == rlhc_pkg::OP_EMIT && !out_busy) begin
      hops <= hop_cnt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ring_lookup_hop_counter_unit.sv =====
// top level of the ring lookup hop counter: config port, sequencer and datapath
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+---------------------------
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//  input    | in_valid, in_ready                | cmd, node_id, key
//  output   | out_valid, out_ready              | hops
//
// after reset a clearing pass sweeps both tables before the first item.
// store: reads the key's successor, then writes the owner table; join: walks backward
// from the node, writing successor entries, until a self link or a full ring.
// query: per hop, the halving loop shrinks the jump, then the successor table's
// single read port reads the entry at the jump target.
// results wait in an output register; a new item is taken while one waits there,
// and a query stalls only when it needs that register while it is still full.
`default_nettype none

module ring_lookup_hop_counter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlhc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rlhc_pkg::CMD_W-1:0]    cmd,
  input  logic [rlhc_pkg::ADDR_W-1:0]   node_id,
  input  logic [rlhc_pkg::ADDR_W-1:0]   key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rlhc_pkg::HOP_W-1:0]    hops
);

  logic [rlhc_pkg::SIZE_W-1:0] ring_size;
  logic [rlhc_pkg::SIZE_W-1:0] wr_val;
  logic [rlhc_pkg::SIZE_W-1:0] ring_size_next;
  logic                        cfg_wr;
  rlhc_pkg::ctrl_t             ctrl;
  rlhc_pkg::status_t           status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rlhc_pkg::REG_RING_SIZE);

  // clamp the written ring size into its legal range
  assign wr_val = pwdata[rlhc_pkg::SIZE_W-1:0];
  always_comb begin
    if (wr_val < rlhc_pkg::RING_MIN) begin
      ring_size_next = rlhc_pkg::RING_MIN;
    end else if (wr_val > rlhc_pkg::RING_RESET) begin
      ring_size_next = rlhc_pkg::RING_RESET;
    end else begin
      ring_size_next = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= rlhc_pkg::RING_RESET;
    end else if (cfg_wr) begin
      ring_size <= ring_size_next;
    end
  end

  // register read back
  assign prdata = (paddr[2] == rlhc_pkg::REG_RING_SIZE)
                  ? {{(32 - rlhc_pkg::SIZE_W){1'b0}}, ring_size} : 32'd0;

  rlhc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  rlhc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .ring_size (ring_size),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .node_id   (node_id),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hops      (hops),
    .status    (status)
  );

`ifndef SYNTHESIS
  // ring size never leaves its clamped range
  assert property (@(posedge clk) disable iff (rst)
    (ring_size >= rlhc_pkg::RING_MIN) && (ring_size <= rlhc_pkg::RING_RESET))
    else $error("ring size out of range");

  // one item at a time: no second accept right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // a result appears only out of the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(ctrl.op) == rlhc_pkg::OP_EMIT))
    else $error("result without a query");

  // the sequencer never waits on the output while taking input
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (ctrl.op != rlhc_pkg::OP_EMIT))
    else $error("input ready during emit");
`endif

endmodule

`default_nettype wire
